### rtl/ttrc_pkg.sv
package ttrc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TERM_W = 16;
   localparam int unsigned PROD_W = 25;

   localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
   localparam logic [TERM_W:0]   MODULUS      = 17'd65535;
   localparam logic [TERM_W:0]   WRAP_BASE    = 17'h10000;

   // recurrence state carried from byte to byte
   typedef struct packed {
      logic [TERM_W-1:0] prev_term;
      logic [TERM_W-1:0] cur_term;
      logic [BYTE_W-1:0] byte_index;
      logic              first_pending;
   } state_type;

   localparam state_type STATE_RESET = '{
      prev_term:     16'd1,
      cur_term:      16'd1,
      byte_index:    8'd0,
      first_pending: 1'b1
   };

   // reduce a 25-bit value modulo 2^16-1 by folding the high part onto the low part
   function automatic logic [TERM_W-1:0] fold_mod(input logic [PROD_W-1:0] x);
      logic [TERM_W:0] sum;
      sum = {1'b0, x[TERM_W-1:0]} + {8'd0, x[PROD_W-1:TERM_W]};
      if (sum >= MODULUS) begin
         sum = sum - MODULUS;
      end
      return sum[TERM_W-1:0];
   endfunction

endpackage

### rtl/ttrc_if.sv
// request channel: one message byte per transaction
interface ttrc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ttrc_pkg::BYTE_W-1:0]    data_byte;
   logic                           last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// response channel: one checksum per message
interface ttrc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ttrc_pkg::TERM_W-1:0]    checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

### rtl/three_term_recurrence_checksum_top.sv
// Three-term recurrence checksum. Bytes of a message arrive on the request channel, one per
// transaction, with last_byte set on the final byte; one 16-bit checksum (0..65534) leaves on
// the response channel per message. The block takes one byte every cycle unless a last byte
// waits for a full response register. That rate is set by the recurrence loop: the state
// register feeds two small multiplies, a subtract and a fold modulo 2^16-1, all combinational
// so the next byte can use the new terms. A checksum is registered: the last byte passes the
// input register, then the response register, before it is valid on the response channel. The
// response register holds a checksum until it is taken; bytes of the next message keep flowing
// meanwhile and only a second last byte waits for it.
module three_term_recurrence_checksum_top (
   input logic      clock,
   input logic      reset,
   ttrc_req_if.sink   req_if,
   ttrc_rsp_if.source rsp_if
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [ttrc_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_last_ff;
   ttrc_pkg::state_type         state_ff;
   ttrc_pkg::state_type         state_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [ttrc_pkg::TERM_W-1:0] rsp_checksum_ff;
   logic [ttrc_pkg::TERM_W-1:0] term;
   logic                        advance;
   logic                        req_take;

   // a byte moves on unless it is a last byte and the response register is still full
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready    = !in_valid_ff || advance;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.checksum = rsp_checksum_ff;

   // recurrence step
   ttrc_step u_step (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_next (state_in),
      .term       (term)
   );

   // input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
   end

   // response register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ttrc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_checksum_ff <= term;
      end
   end

endmodule

### rtl/ttrc_step.sv
module ttrc_step (
   input  ttrc_pkg::state_type         state_cur,
   input  logic [ttrc_pkg::BYTE_W-1:0] data_byte,
   input  logic                        last_byte,
   output ttrc_pkg::state_type         state_next,
   output logic [ttrc_pkg::TERM_W-1:0] term
);

   logic [ttrc_pkg::BYTE_W-1:0] alpha;
   logic [ttrc_pkg::BYTE_W-1:0] beta;
   logic [ttrc_pkg::BYTE_W:0]   coef_a;
   logic [ttrc_pkg::PROD_W-1:0] prod_a;
   logic [ttrc_pkg::PROD_W-1:0] prod_b;
   logic                        diff_neg;
   logic [ttrc_pkg::PROD_W-1:0] diff_mag;
   logic [ttrc_pkg::TERM_W-1:0] mag_mod;
   logic [ttrc_pkg::TERM_W:0]   wrapped;
   logic [ttrc_pkg::TERM_W-1:0] rec_term;

   // position coefficients: 17*i and 31*i, modulo 256
   assign alpha = state_cur.byte_index + {state_cur.byte_index[3:0], 4'd0};
   assign beta  = {state_cur.byte_index[2:0], 5'd0} - state_cur.byte_index;

   // the two products of the recurrence
   assign coef_a = {1'b0, data_byte} + {1'b0, alpha};
   assign prod_a = {16'd0, coef_a} * {9'd0, state_cur.cur_term};
   assign prod_b = {17'd0, beta} * {9'd0, state_cur.prev_term};

   // difference as sign and magnitude
   assign diff_neg = prod_b > prod_a;
   assign diff_mag = diff_neg ? (prod_b - prod_a) : (prod_a - prod_b);
   assign mag_mod  = ttrc_pkg::fold_mod(diff_mag);

   // negative difference wraps to (1 - |d|) mod 2^16-1
   always_comb begin
      wrapped  = ttrc_pkg::WRAP_BASE - {1'b0, mag_mod};
      if (wrapped >= ttrc_pkg::MODULUS) begin
         wrapped = wrapped - ttrc_pkg::MODULUS;
      end
      rec_term = diff_neg ? wrapped[ttrc_pkg::TERM_W-1:0] : mag_mod;
   end

   // next term and state update
   always_comb begin
      if (state_cur.first_pending) begin
         term                     = {8'd0, data_byte} + ttrc_pkg::FIRST_OFFSET;
         state_next.prev_term     = 16'd1;
         state_next.byte_index    = 8'd1;
      end else begin
         term                     = rec_term;
         state_next.prev_term     = state_cur.cur_term;
         state_next.byte_index    = state_cur.byte_index + 8'd1;
      end
      state_next.cur_term      = term;
      state_next.first_pending = 1'b0;
      if (last_byte) begin
         state_next = ttrc_pkg::STATE_RESET;
      end
   end

endmodule

### rtl/ttrc_checker.sv
module ttrc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ttrc_pkg::TERM_W-1:0] rsp_checksum
);

   // a stalled response keeps its checksum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum))
      else $error("response changed while stalled");

   // checksum is a residue modulo 2^16-1
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_checksum != 16'hFFFF)
      else $error("checksum out of range");

   // reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // a fresh response follows an accepted last byte, through the input and response registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("response without a last byte");

endmodule

bind three_term_recurrence_checksum_top ttrc_checker u_ttrc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_last     (req_if.last_byte),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_checksum (rsp_if.checksum)
);
